>>> hw/rtl/rfb_pkg.sv
// Shared constants and types for the RRIP frequency/bypass replacement block.
package rfb_pkg;

  localparam int NUM_SETS    = 2048;
  localparam int NUM_WAYS    = 16;

  localparam int SET_IDX_W   = 11;
  localparam int WAY_IDX_W   = 4;
  localparam int TAG_W       = 58;
  localparam int MASK_W      = 16;
  localparam int WIN_W       = 8;
  localparam int OUT_WAY_W   = 4;

  localparam int SET_W       = $clog2(NUM_SETS);
  localparam int WAY_W       = $clog2(NUM_WAYS);
  localparam int ADDR_W      = SET_W + WAY_W;

  localparam int RRPV_W      = 2;
  localparam int FREQ_W      = 3;

  localparam logic [RRPV_W-1:0] RRPV_TOP    = 2'd3;
  localparam logic [RRPV_W-1:0] RRPV_INS    = 2'd2;
  localparam logic [FREQ_W-1:0] FREQ_SAT    = 3'd7;
  localparam logic [FREQ_W-1:0] FILL_FREQ   = 3'd1;
  localparam logic [FREQ_W-1:0] THR_RESET   = 3'd1;
  localparam logic [WIN_W-1:0]  WIN_RESET   = 8'd4;

  localparam logic [WAY_W-1:0]  WAY_LAST    = WAY_W'(NUM_WAYS - 1);

  typedef struct packed {
    logic                 valid;
    logic [TAG_W-1:0]     tag;
    logic [RRPV_W-1:0]    rrpv;
    logic [FREQ_W-1:0]    freq;
    logic                 spatial;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t RESET_ENTRY = '{
    valid:   1'b0,
    tag:     '0,
    rrpv:    RRPV_TOP,
    freq:    '0,
    spatial: 1'b0
  };

  // One way read issued to the scan unit
  typedef struct packed {
    logic             vld;
    logic [WAY_W-1:0] way;
    logic             last;
  } scan_issue_t;

  // Outcome of a full pass over the ways of one set
  typedef struct packed {
    logic              done;
    logic              spatial;
    logic [RRPV_W-1:0] top_rrpv;
    logic [WAY_W-1:0]  best_way;
    entry_t            old;
  } scan_res_t;

endpackage

>>> hw/rtl/rfb_meta_ram.sv
// Generic single-write, single-read memory with registered read data.
module rfb_meta_ram #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 65
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [(2**ADDR_W)];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/rfb_way_scan.sv
// Shared per-way unit: tag distance check, victim tracking, target capture.
module rfb_way_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rfb_pkg::WIN_W-1:0]    window,
  input  logic [rfb_pkg::TAG_W-1:0]    line_addr,
  input  logic [rfb_pkg::WAY_W-1:0]    tgt_way,
  input  rfb_pkg::scan_issue_t         issue,
  input  logic [rfb_pkg::ENTRY_W-1:0]  rd_data,
  output rfb_pkg::scan_res_t           res
);
  import rfb_pkg::*;

  scan_issue_t        s0_r;
  scan_issue_t        s1_r;
  logic [TAG_W:0]     diff_r;
  logic               tval_r;
  logic               acc_r;
  logic               found_r;
  logic [RRPV_W-1:0]  max_r;
  logic [FREQ_W-1:0]  bestf_r;
  logic [WAY_W-1:0]   best_r;
  entry_t             old_r;
  entry_t             ent;
  logic               near_now;

  // Absolute distance of a signed difference against the window
  function automatic logic near_fn(input logic [TAG_W:0] d, input logic [WIN_W-1:0] w);
    logic [WIN_W:0] sum;
    logic           pos_ok;
    logic           neg_ok;
    sum    = {1'b0, d[WIN_W-1:0]} + {1'b0, w};
    pos_ok = !d[TAG_W] && (d[TAG_W-1:WIN_W] == '0) && (d[WIN_W-1:0] <= w);
    neg_ok = d[TAG_W] && (&d[TAG_W-1:WIN_W]) && (d[WIN_W-1:0] != '0) && sum[WIN_W];
    return pos_ok || neg_ok;
  endfunction

  assign ent      = entry_t'(rd_data);
  assign near_now = s1_r.vld && tval_r && near_fn(diff_r, window);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r    <= '0;
      s1_r    <= '0;
      acc_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      s0_r <= issue;
      s1_r <= s0_r;
      if (start) begin
        acc_r   <= 1'b0;
        found_r <= 1'b0;
      end else begin
        if (near_now) begin
          acc_r <= 1'b1;
        end
        if (s0_r.vld) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  // Payload side: difference stage, victim tracking and target capture
  always_ff @(posedge clk) begin
    diff_r <= {1'b0, line_addr} - {1'b0, ent.tag};
    tval_r <= ent.valid;
    if (s0_r.vld) begin
      if (!found_r || (ent.rrpv > max_r)) begin
        max_r   <= ent.rrpv;
        bestf_r <= ent.freq;
        best_r  <= s0_r.way;
      end else if ((ent.rrpv == max_r) && (ent.freq < bestf_r)) begin
        bestf_r <= ent.freq;
        best_r  <= s0_r.way;
      end
      if (s0_r.way == tgt_way) begin
        old_r <= ent;
      end
    end
  end

  always_comb begin
    res.done     = s1_r.vld && s1_r.last;
    res.spatial  = acc_r || near_now;
    res.top_rrpv = max_r;
    res.best_way = best_r;
    res.old      = old_r;
  end

endmodule

>>> hw/rtl/rrip_frequency_bypass_replacement_core.sv
// Top level: sequencer, clearing sweep, configuration and result register.
//
//   channel | ports                         | handshake
//   --------+-------------------------------+-------------------------------
//   input   | in_mode .. in_cache_valid_mask| in_valid / in_ready
//   result  | out_victim_way, out_bypassed  | out_valid / out_ready
//   config  | cfg_wr_data (neighbour window)| cfg_wr_en, no wait
//
// Paths from the accepting cycle to the load of the result register: a query
// answered from the cache mask, or an update to a way out of range, goes
// straight to ST_DONE. Any other item runs one pass over the ways through the
// single metadata RAM read port; a query that must age the set adds a second
// pass that reads and writes back every way.
// Reset: a clearing sweep writes all NUM_SETS * 2**WAY_W (32768) RAM entries
// with in_ready low; configuration writes are taken throughout.
// Stalls: one item at a time; a held result blocks only the next completion.
module rrip_frequency_bypass_replacement_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [rfb_pkg::SET_IDX_W-1:0]  in_set_index,
  input  logic [rfb_pkg::WAY_IDX_W-1:0]  in_way_index,
  input  logic [rfb_pkg::TAG_W-1:0]      in_line_addr,
  input  logic                           in_is_hit,
  input  logic                           in_victim_present,
  input  logic [rfb_pkg::MASK_W-1:0]     in_cache_valid_mask,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rfb_pkg::OUT_WAY_W-1:0]  out_victim_way,
  output logic                           out_bypassed,
  input  logic                           cfg_wr_en,
  input  logic [rfb_pkg::WIN_W-1:0]      cfg_wr_data
);
  import rfb_pkg::*;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_WAIT     = 3'd3;
  localparam logic [2:0] ST_AGE      = 3'd4;
  localparam logic [2:0] ST_AGE_WAIT = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  // Only the low mask bits that name real ways are examined
  localparam int MASK_LOOK = (NUM_WAYS < MASK_W) ? NUM_WAYS : MASK_W;

  logic [2:0]            state_r,   state_nxt;
  logic [ADDR_W-1:0]     clr_r,     clr_nxt;
  logic [WAY_W-1:0]      cnt_r,     cnt_nxt;
  logic [SET_W-1:0]      set_r,     set_nxt;
  logic [WAY_W-1:0]      way_r,     way_nxt;
  logic [TAG_W-1:0]      line_r,    line_nxt;
  logic                  mode_r,    mode_nxt;
  logic                  hit_r,     hit_nxt;
  logic                  vp_r,      vp_nxt;
  logic [RRPV_W-1:0]     age_r,     age_nxt;
  logic                  age_vld_r, age_vld_nxt;
  logic [WAY_W-1:0]      age_way_r, age_way_nxt;
  logic [OUT_WAY_W-1:0]  res_way_r, res_way_nxt;
  logic                  res_byp_r, res_byp_nxt;
  logic [FREQ_W-1:0]     thr_r,     thr_nxt;
  logic [WIN_W-1:0]      win_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_WAY_W-1:0]  out_way_r,   out_way_nxt;
  logic                  out_byp_r,   out_byp_nxt;

  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  entry_t                wr_data;
  logic [ENTRY_W-1:0]    rd_data;
  scan_issue_t           issue;
  scan_res_t             scan_res;
  logic                  scan_start;

  logic                  free_any;
  logic [OUT_WAY_W-1:0]  free_way;
  logic                  way_ok;

  rfb_meta_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rfb_way_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .window    (win_r),
    .line_addr (line_r),
    .tgt_way   (way_r),
    .issue     (issue),
    .rd_data   (rd_data),
    .res       (scan_res)
  );

  // Lowest way that the cache marks invalid
  always_comb begin
    free_any = 1'b0;
    free_way = '0;
    for (int i = MASK_LOOK - 1; i >= 0; i--) begin
      if (!in_cache_valid_mask[i]) begin
        free_any = 1'b1;
        free_way = OUT_WAY_W'(i);
      end
    end
  end

  assign way_ok   = ({1'b0, in_way_index} < (WAY_IDX_W + 1)'(NUM_WAYS));
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    entry_t upd;
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    set_nxt       = set_r;
    way_nxt       = way_r;
    line_nxt      = line_r;
    mode_nxt      = mode_r;
    hit_nxt       = hit_r;
    vp_nxt        = vp_r;
    age_nxt       = age_r;
    age_vld_nxt   = 1'b0;
    age_way_nxt   = age_way_r;
    res_way_nxt   = res_way_r;
    res_byp_nxt   = res_byp_r;
    thr_nxt       = thr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_way_nxt   = out_way_r;
    out_byp_nxt   = out_byp_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = RESET_ENTRY;
    issue         = '0;
    scan_start    = 1'b0;
    upd           = scan_res.old;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = RESET_ENTRY;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          // set index wraps on the set count, a power of two
          set_nxt     = in_set_index[SET_W-1:0];
          way_nxt     = in_way_index[WAY_W-1:0];
          line_nxt    = in_line_addr;
          mode_nxt    = in_mode;
          hit_nxt     = in_is_hit;
          vp_nxt      = in_victim_present;
          res_way_nxt = '0;
          res_byp_nxt = 1'b0;
          cnt_nxt     = '0;
          if (!in_mode && free_any) begin
            res_way_nxt = free_way;
            state_nxt   = ST_DONE;
          end else if (in_mode && !way_ok) begin
            state_nxt = ST_DONE;
          end else begin
            scan_start = 1'b1;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en      = 1'b1;
        rd_addr    = {set_r, cnt_r};
        issue.vld  = 1'b1;
        issue.way  = cnt_r;
        issue.last = (cnt_r == WAY_LAST);
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == WAY_LAST) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (scan_res.done) begin
          if (!mode_r) begin
            res_way_nxt = OUT_WAY_W'(scan_res.best_way);
            if (scan_res.top_rrpv == RRPV_TOP) begin
              state_nxt = ST_DONE;
            end else begin
              // age the whole set in one pass so that the top way reaches the maximum
              age_nxt   = RRPV_TOP - scan_res.top_rrpv;
              cnt_nxt   = '0;
              state_nxt = ST_AGE;
            end
          end else begin
            wr_en   = 1'b1;
            wr_addr = {set_r, way_r};
            if (hit_r) begin
              upd.rrpv = '0;
              if (upd.freq < FREQ_SAT) begin
                upd.freq = upd.freq + 1'b1;
              end
              upd.spatial = scan_res.spatial;
            end else if ((thr_r >= FILL_FREQ) && !scan_res.spatial) begin
              upd         = RESET_ENTRY;
              res_byp_nxt = 1'b1;
            end else begin
              upd.valid   = 1'b1;
              upd.tag     = line_r;
              upd.freq    = FILL_FREQ;
              upd.spatial = scan_res.spatial;
              upd.rrpv    = scan_res.spatial ? RRPV_INS : RRPV_TOP;
              if (vp_r && scan_res.old.valid && (scan_res.old.freq <= FILL_FREQ) &&
                  (thr_r < FREQ_SAT)) begin
                thr_nxt = thr_r + 1'b1;
              end
            end
            wr_data   = upd;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_AGE: begin
        rd_en       = 1'b1;
        rd_addr     = {set_r, cnt_r};
        age_vld_nxt = 1'b1;
        age_way_nxt = cnt_r;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == WAY_LAST) begin
          state_nxt = ST_AGE_WAIT;
        end
      end
      ST_AGE_WAIT: begin
        // last aged way is written back in this cycle
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_way_nxt   = res_way_r;
          out_byp_nxt   = res_byp_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Write back an aged way in the cycle after its read
    if (age_vld_r) begin
      upd     = entry_t'(rd_data);
      upd.rrpv = upd.rrpv + age_r;
      wr_en   = 1'b1;
      wr_addr = {set_r, age_way_r};
      wr_data = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      age_vld_r   <= 1'b0;
      thr_r       <= THR_RESET;
      win_r       <= WIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      age_vld_r   <= age_vld_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    set_r     <= set_nxt;
    way_r     <= way_nxt;
    line_r    <= line_nxt;
    mode_r    <= mode_nxt;
    hit_r     <= hit_nxt;
    vp_r      <= vp_nxt;
    age_r     <= age_nxt;
    age_way_r <= age_way_nxt;
    res_way_r <= res_way_nxt;
    res_byp_r <= res_byp_nxt;
    out_way_r <= out_way_nxt;
    out_byp_r <= out_byp_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_victim_way = out_way_r;
  assign out_bypassed   = out_byp_r;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the RRIP replacement metadata core with frequency and fill bypass.
module tb_top;
  import rfb_pkg::*;

  // Request codes carried by in_mode and in_is_hit
  localparam logic MODE_QUERY  = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;
  localparam logic UPD_FILL    = 1'b0;
  localparam logic UPD_HIT     = 1'b1;

  localparam logic [MASK_W-1:0] ALL_VALID = '1;

  localparam int RESET_CYCLES  = 6;
  // Longest walk through the core: one pass over the ways plus an ageing pass
  localparam int SETTLE_CYCLES = 2 * NUM_WAYS + 8;
  // Clearing sweep plus ~630 transfers with their idling, several times over
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic                 mode;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_IDX_W-1:0] way_index;
    logic [TAG_W-1:0]     line_addr;
    logic                 is_hit;
    logic                 victim_present;
    logic [MASK_W-1:0]    valid_mask;
  } repl_req_t;

  typedef struct packed {
    logic [OUT_WAY_W-1:0] victim_way;
    logic                 bypassed;
  } repl_resp_t;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 out_ready   = 1'b0;
  logic                 cfg_wr_en   = 1'b0;
  logic [WIN_W-1:0]     cfg_wr_data = '0;
  repl_req_t            cur_req     = '0;

  logic                 in_ready;
  logic                 out_valid;
  logic [OUT_WAY_W-1:0] out_victim_way;
  logic                 out_bypassed;

  logic                 in_mode;
  logic [SET_IDX_W-1:0] in_set_index;
  logic [WAY_IDX_W-1:0] in_way_index;
  logic [TAG_W-1:0]     in_line_addr;
  logic                 in_is_hit;
  logic                 in_victim_present;
  logic [MASK_W-1:0]    in_cache_valid_mask;

  // Payload ports follow the request register, which only moves at a rising edge
  assign in_mode             = cur_req.mode;
  assign in_set_index        = cur_req.set_index;
  assign in_way_index        = cur_req.way_index;
  assign in_line_addr        = cur_req.line_addr;
  assign in_is_hit           = cur_req.is_hit;
  assign in_victim_present   = cur_req.victim_present;
  assign in_cache_valid_mask = cur_req.valid_mask;

  // Shadow copy of the replacement metadata and the adaptive state
  entry_t            shadow [NUM_SETS][NUM_WAYS];
  logic [FREQ_W-1:0] bypass_thr;
  logic [WIN_W-1:0]  window_shadow;

  repl_req_t  req_queue [$];   // requests not yet offered to the core
  repl_resp_t resp_queue [$];  // answers owed by the core, oldest first
  repl_resp_t exp_resp;

  int errors    = 0;
  int cycle_cnt = 0;
  int in_gap    = 0;
  int out_stall = 0;
  bit calm      = 1'b0;  // suppress idling on both sides for a whole phase

  rrip_frequency_bypass_replacement_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_set_index        (in_set_index),
    .in_way_index        (in_way_index),
    .in_line_addr        (in_line_addr),
    .in_is_hit           (in_is_hit),
    .in_victim_present   (in_victim_present),
    .in_cache_valid_mask (in_cache_valid_mask),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_victim_way      (out_victim_way),
    .out_bypassed        (out_bypassed),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // True when any valid way of the set holds a tag within the spatial window
  function automatic logic tag_is_near(int s, logic [TAG_W-1:0] t);
    logic [TAG_W-1:0] span;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (shadow[s][w].valid) begin
        span = (t > shadow[s][w].tag) ? t - shadow[s][w].tag : shadow[s][w].tag - t;
        if (span <= TAG_W'(window_shadow)) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Lowest way the cache marks invalid, else the least-frequency way at the
  // top RRPV, ageing the whole set until one way gets there
  function automatic logic [OUT_WAY_W-1:0] choose_victim(int s, logic [MASK_W-1:0] mask);
    int best;
    bit found;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (w < MASK_W && !mask[w]) return OUT_WAY_W'(w);
    end
    for (int round = 0; round <= int'(RRPV_TOP); round++) begin
      found = 1'b0;
      best  = 0;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (shadow[s][w].rrpv == RRPV_TOP &&
            (!found || shadow[s][w].freq < shadow[s][best].freq)) begin
          best  = w;
          found = 1'b1;
        end
      end
      if (found) return OUT_WAY_W'(best);
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (shadow[s][w].rrpv < RRPV_TOP) shadow[s][w].rrpv = shadow[s][w].rrpv + 1'b1;
      end
    end
    return '0;
  endfunction

  // Advance the shadow state by one request and return the answer it owes
  function automatic repl_resp_t predict_repl(repl_req_t r);
    repl_resp_t        res;
    int                s;
    int                w;
    logic              near;
    logic              old_valid;
    logic [FREQ_W-1:0] old_freq;
    res = '0;
    s   = int'(r.set_index) % NUM_SETS;
    w   = int'(r.way_index);
    if (r.mode == MODE_QUERY) begin
      res.victim_way = choose_victim(s, r.valid_mask);
      return res;
    end
    if (w >= NUM_WAYS) return res;
    near = tag_is_near(s, r.line_addr);
    if (r.is_hit == UPD_HIT) begin
      shadow[s][w].rrpv = '0;
      if (shadow[s][w].freq < FREQ_SAT) shadow[s][w].freq = shadow[s][w].freq + 1'b1;
      shadow[s][w].spatial = near;
      return res;
    end
    old_valid = shadow[s][w].valid;
    old_freq  = shadow[s][w].freq;
    if (bypass_thr >= FILL_FREQ && !near) begin
      shadow[s][w] = RESET_ENTRY;
      res.bypassed = 1'b1;
      return res;
    end
    shadow[s][w].valid   = 1'b1;
    shadow[s][w].tag     = r.line_addr;
    shadow[s][w].freq    = FILL_FREQ;
    shadow[s][w].spatial = near;
    shadow[s][w].rrpv    = near ? RRPV_INS : RRPV_TOP;
    if (r.victim_present && old_valid && old_freq <= FILL_FREQ && bypass_thr < FREQ_SAT)
      bypass_thr = bypass_thr + 1'b1;
    return res;
  endfunction

  function automatic repl_req_t make_req(logic mode, int s, int w, logic [TAG_W-1:0] addr,
                                         logic hit, logic vp, logic [MASK_W-1:0] mask);
    repl_req_t r;
    r.mode           = mode;
    r.set_index      = SET_IDX_W'(s);
    r.way_index      = WAY_IDX_W'(w);
    r.line_addr      = addr;
    r.is_hit         = hit;
    r.victim_present = vp;
    r.valid_mask     = mask;
    return r;
  endfunction

  // Mostly random tags, with the two ends of the range now and then
  function automatic logic [TAG_W-1:0] rand_tag();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return TAG_W'({$urandom, $urandom});
  endfunction

  // Idle length: mostly none, often short, rarely long
  function automatic int pick_idle();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 15);
    if (roll < 9) return 0;
    if (roll == 15) return $urandom_range(20, 80);
    return $urandom_range(1, 4);
  endfunction

  // Hold the sender until every owed answer is back, then let the core settle
  task automatic wait_quiet();
    while (req_queue.size() != 0 || in_valid || resp_queue.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(logic [WIN_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    window_shadow  = v;
  endtask

  // One phase of random traffic under a new spatial window. Most of it is
  // well-formed: queries followed by fills, bursts of hits that drive a set
  // towards ageing, queries with holes in the mask, and a little noise on arbitrary sets.
  task automatic run_random_phase(int n_items, logic [WIN_W-1:0] win, bit quiet);
    int               done_cnt;
    int               hot [3];
    int               s;
    int               k;
    int               start;
    int               stride;
    int               kind;
    logic [MASK_W-1:0] m;
    wait_quiet();
    write_window(win);
    calm   = quiet;
    hot[0] = $urandom_range(0, NUM_SETS - 1);
    hot[1] = $urandom_range(0, NUM_SETS - 1);
    hot[2] = $urandom_range(0, 1) ? NUM_SETS - 1 : 0;
    @(negedge clk);
    done_cnt = 0;
    while (done_cnt < n_items) begin
      s    = hot[$urandom_range(0, 2)];
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        // victim query on a full set, then the fill that follows it
        req_queue.push_back(make_req(MODE_QUERY, s, $urandom_range(0, 15), rand_tag(),
                                     1'($urandom), 1'($urandom), ALL_VALID));
        req_queue.push_back(make_req(MODE_UPDATE, s, $urandom_range(0, 15), rand_tag(),
                                     UPD_FILL, 1'($urandom), MASK_W'($urandom)));
        done_cnt += 2;
      end else if (kind < 6) begin
        // hit a run of distinct ways; an odd stride walks a permutation
        k      = $urandom_range(1, NUM_WAYS);
        start  = $urandom_range(0, NUM_WAYS - 1);
        stride = 2 * $urandom_range(0, 7) + 1;
        for (int i = 0; i < k; i++)
          req_queue.push_back(make_req(MODE_UPDATE, s, (start + i * stride) % NUM_WAYS,
                                       rand_tag(), UPD_HIT, 1'($urandom),
                                       MASK_W'($urandom)));
        req_queue.push_back(make_req(MODE_QUERY, s, 0, rand_tag(), 1'($urandom),
                                     1'($urandom), ALL_VALID));
        done_cnt += k + 1;
      end else if (kind < 8) begin
        // query with one hole, or with a random cache mask
        m = $urandom_range(0, 1) ? ALL_VALID ^ (MASK_W'(1) << $urandom_range(0, 15))
                                 : MASK_W'($urandom);
        req_queue.push_back(make_req(MODE_QUERY, s, $urandom_range(0, 15), rand_tag(),
                                     1'($urandom), 1'($urandom), m));
        done_cnt += 1;
      end else if (kind == 8) begin
        req_queue.push_back(make_req(MODE_UPDATE, s, $urandom_range(0, 15), rand_tag(),
                                     1'($urandom), 1'($urandom), MASK_W'($urandom)));
        done_cnt += 1;
      end else begin
        // noise: any set, any field
        req_queue.push_back(make_req(1'($urandom), $urandom_range(0, NUM_SETS - 1),
                                     $urandom_range(0, 15), rand_tag(), 1'($urandom),
                                     1'($urandom), MASK_W'($urandom)));
        done_cnt += 1;
      end
    end
  endtask

  // Driver: offer the next request, hold it until the transfer, then idle a while
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) resp_queue.push_back(predict_repl(cur_req));
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (req_queue.size() != 0) begin
          cur_req  <= req_queue.pop_front();
          in_valid <= 1'b1;
          in_gap   <= pick_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, check each result transfer against the oldest answer owed
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (resp_queue.size() == 0) begin
        $error("unexpected result: victim_way %0d bypassed %0d", out_victim_way, out_bypassed);
        errors++;
      end else begin
        exp_resp = resp_queue.pop_front();
        if (out_victim_way !== exp_resp.victim_way) begin
          $error("victim_way mismatch: expected %0d, actual %0d",
                 exp_resp.victim_way, out_victim_way);
          errors++;
        end
        if (out_bypassed !== exp_resp.bypassed) begin
          $error("bypassed mismatch: expected %0d, actual %0d", exp_resp.bypassed, out_bypassed);
          errors++;
        end
      end
    end
    if (out_stall != 0) begin
      out_ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall <= pick_idle();
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    for (int s = 0; s < NUM_SETS; s++)
      for (int w = 0; w < NUM_WAYS; w++) shadow[s][w] = RESET_ENTRY;
    bypass_thr    = THR_RESET;
    window_shadow = WIN_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset window. The core is still sweeping its
    // RAM, so these wait on in_ready.
    // lowest way the cache marks invalid
    req_queue.push_back(make_req(MODE_QUERY, 0, 0, '0, UPD_FILL, 1'b0, '0));
    req_queue.push_back(make_req(MODE_QUERY, NUM_SETS - 1, 15, '1, UPD_HIT, 1'b1, 16'h7FFF));
    // promote every way of the top set so that the next full query must age
    for (int w = 0; w < NUM_WAYS; w++)
      req_queue.push_back(make_req(MODE_UPDATE, NUM_SETS - 1, w, w[0] ? '1 : '0,
                                   UPD_HIT, w[0], ALL_VALID));
    req_queue.push_back(make_req(MODE_QUERY, NUM_SETS - 1, 0, '0, UPD_FILL, 1'b0, ALL_VALID));
    // drive one frequency counter into saturation
    repeat (7)
      req_queue.push_back(make_req(MODE_UPDATE, NUM_SETS - 1, 9, rand_tag(), UPD_HIT,
                                   1'b0, '0));
    // fill with no spatial neighbour: bypass and clear, then it is the least-frequency victim
    req_queue.push_back(make_req(MODE_UPDATE, NUM_SETS - 1, 9, rand_tag(), UPD_FILL,
                                 1'b1, '0));
    req_queue.push_back(make_req(MODE_QUERY, NUM_SETS - 1, 0, '0, UPD_FILL, 1'b0, ALL_VALID));

    // Random phases across the window range, one of them with no idling at all
    run_random_phase(100, 8'd255, 1'b0);
    run_random_phase(100, 8'd0, 1'b0);
    run_random_phase(100, WIN_W'($urandom), 1'b1);
    run_random_phase(100, 8'd1, 1'b0);
    run_random_phase(100, WIN_W'($urandom), 1'b0);
    run_random_phase(100, 8'd128, 1'b0);

    wait_quiet();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> rrip_frequency_bypass_replacement_core.f
hw/rtl/rfb_pkg.sv
hw/rtl/rfb_meta_ram.sv
hw/rtl/rfb_way_scan.sv
hw/rtl/rrip_frequency_bypass_replacement_core.sv
tb/tb_top.sv
